### design/rycc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rycc_pkg
// Shared types, coefficient tables and width helpers for the RGB/YCbCr
// converter pipeline.
// ----------------------------------------------------------------------------
package rycc_pkg;

	// conversion direction codes
	localparam logic DIR_FWD = 1'b0;   // RGB to YCbCr
	localparam logic DIR_REV = 1'b1;   // YCbCr to RGB

	localparam int NUM_CH = 3;
	localparam int COEF_W = 18;

	typedef logic signed [COEF_W-1:0] coef_t;

	// per-stage control that travels with the data
	typedef struct packed {
		logic valid;
		logic dir;
	} rycc_ctl_t;

	// coefficient matrices, 16 fraction bits, [output][input]
	localparam coef_t FWD_COEF [NUM_CH][NUM_CH] = '{
		'{ 18'sd19589,  18'sd38443,  18'sd7504  },
		'{-18'sd11056, -18'sd21712,  18'sd32768 },
		'{ 18'sd32768, -18'sd27420, -18'sd5348  }
	};
	localparam coef_t REV_COEF [NUM_CH][NUM_CH] = '{
		'{ 18'sd65536,  18'sd0,      18'sd91895 },
		'{ 18'sd65536, -18'sd22649, -18'sd46825 },
		'{ 18'sd65536,  18'sd116064, 18'sd0     }
	};

	// chroma offset of 128 with 16 fraction bits, forward only
	localparam int FWD_BASE = 8388608;

	// signed operand width: holds a 16-bit input and a chroma difference
	function automatic int rycc_opw(input int frac);
		return (frac > 7) ? frac + 10 : 18;
	endfunction

endpackage
`default_nettype wire

### design/rycc_operand.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rycc_operand
// Stage 1: picks the three signed multiplier operands for the direction:
// the pixel bytes (forward) or luma and the centered chroma values (reverse).
// ----------------------------------------------------------------------------
module rycc_operand import rycc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire rycc_ctl_t        ctl_in,
	input  wire logic [15:0]      comp_first,
	input  wire logic [15:0]      comp_second,
	input  wire logic [15:0]      comp_third,
	output rycc_ctl_t             ctl_s1,
	output logic signed [rycc_opw(FRAC_BITS)-1:0] x_s1 [NUM_CH]
);
	localparam int DW = rycc_opw(FRAC_BITS);
	localparam logic signed [DW-1:0] CHROMA_OFF = DW'(128 << FRAC_BITS);

	logic [15:0]          comp [NUM_CH];
	logic [15:0]          shifted;
	logic signed [DW-1:0] x_nxt [NUM_CH];

	assign comp[0] = comp_first;
	assign comp[1] = comp_second;
	assign comp[2] = comp_third;

	// operand select
	always_comb begin
		shifted = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			shifted = comp[i] >> FRAC_BITS;
			if (ctl_in.dir == DIR_FWD) begin
				x_nxt[i] = DW'(shifted[7:0]);
			end else if (i == 0) begin
				x_nxt[i] = DW'(comp[i]);
			end else begin
				x_nxt[i] = DW'(comp[i]) - CHROMA_OFF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_nxt;
		end
	end

endmodule
`default_nettype wire

### design/rycc_matmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rycc_matmul
// Stages 2 and 3: nine constant-coefficient products, registered, then the
// three row sums with the forward chroma offset.
// ----------------------------------------------------------------------------
module rycc_matmul import rycc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en_s2,
	input  wire logic      en_s3,
	input  wire rycc_ctl_t ctl_s1,
	input  wire logic signed [rycc_opw(FRAC_BITS)-1:0] x_s1 [NUM_CH],
	output rycc_ctl_t      ctl_s3,
	output logic signed [rycc_opw(FRAC_BITS)+COEF_W+1:0] acc_s3 [NUM_CH]
);
	localparam int DW = rycc_opw(FRAC_BITS);
	localparam int PW = DW + COEF_W;
	localparam int AW = PW + 2;

	rycc_ctl_t            ctl_s2;
	logic signed [PW-1:0] prod_s2 [NUM_CH][NUM_CH];
	logic signed [PW-1:0] prod_nxt [NUM_CH][NUM_CH];
	logic signed [AW-1:0] acc_nxt [NUM_CH];

	// products, coefficient set chosen by direction
	always_comb begin
		for (int r = 0; r < NUM_CH; r++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (ctl_s1.dir == DIR_FWD) begin
					prod_nxt[r][c] = PW'(x_s1[c]) * PW'(FWD_COEF[r][c]);
				end else begin
					prod_nxt[r][c] = PW'(x_s1[c]) * PW'(REV_COEF[r][c]);
				end
			end
		end
	end

	// row sums
	always_comb begin
		for (int r = 0; r < NUM_CH; r++) begin
			acc_nxt[r] = AW'(prod_s2[r][0]) + AW'(prod_s2[r][1]) + AW'(prod_s2[r][2]);
			if (ctl_s2.dir == DIR_FWD && r != 0) begin
				acc_nxt[r] = acc_nxt[r] + AW'(FWD_BASE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (en_s2) begin
				ctl_s2 <= ctl_s1;
			end
			if (en_s3) begin
				ctl_s3 <= ctl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= prod_nxt;
		end
		if (en_s3) begin
			acc_s3 <= acc_nxt;
		end
	end

endmodule
`default_nettype wire

### design/rycc_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rycc_round
// Stage 4: rounds the sums to the output format and saturates. Forward
// gives Q-format chroma/luma; reverse gives a byte placed at FRAC_BITS.
// ----------------------------------------------------------------------------
module rycc_round import rycc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire rycc_ctl_t ctl_s3,
	input  wire logic signed [rycc_opw(FRAC_BITS)+COEF_W+1:0] acc_s3 [NUM_CH],
	output rycc_ctl_t      ctl_s4,
	output logic [15:0]    res_s4 [NUM_CH]
);
	localparam int AW     = rycc_opw(FRAC_BITS) + COEF_W + 2;
	localparam int FWD_SH = 16 - FRAC_BITS;
	localparam int REV_SH = 16 + FRAC_BITS;
	localparam logic signed [AW:0] FWD_HALF = (AW+1)'(1 << (FWD_SH - 1));
	localparam logic signed [AW:0] REV_HALF = (AW+1)'(1 << (REV_SH - 1));
	localparam logic signed [AW:0] MAX16    = (AW+1)'(65535);
	localparam logic signed [AW:0] MAX8     = (AW+1)'(255);
	localparam logic [15:0] FRAC_MASK = 16'((32'd1 << FRAC_BITS) - 32'd1);

	logic signed [AW:0] q_fwd [NUM_CH];
	logic signed [AW:0] q_rev [NUM_CH];
	logic               pos   [NUM_CH];
	logic [7:0]         byte_val [NUM_CH];
	logic [31:0]        placed   [NUM_CH];
	logic [15:0]        res_nxt  [NUM_CH];

	// round half up, clamp at zero and at the format limit
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			pos[i]   = !acc_s3[i][AW-1] && (acc_s3[i] != '0);
			q_fwd[i] = ((AW+1)'(acc_s3[i]) + FWD_HALF) >>> FWD_SH;
			q_rev[i] = ((AW+1)'(acc_s3[i]) + REV_HALF) >>> REV_SH;
			if (!pos[i]) begin
				byte_val[i] = 8'd0;
			end else if (q_rev[i] > MAX8) begin
				byte_val[i] = 8'hFF;
			end else begin
				byte_val[i] = q_rev[i][7:0];
			end
			placed[i] = 32'(byte_val[i]) << FRAC_BITS;
			if (ctl_s3.dir == DIR_REV) begin
				res_nxt[i] = placed[i][15:0];
			end else if (!pos[i]) begin
				res_nxt[i] = 16'd0;
			end else if (q_fwd[i] > MAX16) begin
				res_nxt[i] = 16'hFFFF;
			end else begin
				res_nxt[i] = q_fwd[i][15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res_nxt;
		end
	end

	// reverse results never carry fraction bits
	a_rev_no_frac: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s4.valid && ctl_s4.dir == DIR_REV |->
		((res_s4[0] & FRAC_MASK) == 16'd0) && ((res_s4[1] & FRAC_MASK) == 16'd0)
		&& ((res_s4[2] & FRAC_MASK) == 16'd0))
		else $error("reverse result has nonzero fraction bits");

endmodule
`default_nettype wire

### design/rgb_ycbcr_color_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_converter
// Pixel color-space converter, RGB <-> YCbCr with BT.601-style coefficients.
//
// Input channel pix_valid/pix_ready carries one pixel request (comp_first,
// comp_second, comp_third); output channel res_valid/res_ready carries one
// result (res_first, res_second, res_third) per request, in order.
// cfg_wr_en/cfg_wr_data writes the direction register (0: RGB to YCbCr,
// 1: YCbCr to RGB); write it only while the pipeline is empty.
// Four register stages: operand select, multiply, row sum, round/saturate.
// The first is loaded at the accepting edge; the pixel then passes the
// multiply, row-sum and round/saturate registers before res_valid rises.
// Throughput is one pixel per clock while the receiver does not stall; the
// nine constant multipliers are fully pipelined.
// Reset clears all stage valid bits and sets the direction to forward.
// When the receiver stalls, the last stage holds its result and bubbles
// ahead of it are filled; pix_ready drops only once all four stages hold
// a pixel.
// ----------------------------------------------------------------------------
module rgb_ycbcr_color_converter import rycc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        pix_valid,
	output logic             pix_ready,
	input  wire logic [15:0] comp_first,
	input  wire logic [15:0] comp_second,
	input  wire logic [15:0] comp_third,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [15:0]      res_first,
	output logic [15:0]      res_second,
	output logic [15:0]      res_third
);
	localparam int DW = rycc_opw(FRAC_BITS);
	localparam int AW = DW + COEF_W + 2;

	logic                 direction_q;
	rycc_ctl_t            ctl_in;
	rycc_ctl_t            ctl_s1;
	rycc_ctl_t            ctl_s3;
	rycc_ctl_t            ctl_s4;
	logic signed [DW-1:0] x_s1   [NUM_CH];
	logic signed [AW-1:0] acc_s3 [NUM_CH];
	logic [15:0]          res_s4 [NUM_CH];
	logic                 en_s1, en_s2, en_s3, en_s4;
	logic                 v_s2;

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_FWD;
		end else if (cfg_wr_en) begin
			direction_q <= cfg_wr_data;
		end
	end

	// stage enables: a stage moves when empty or when the next one moves
	assign en_s4 = !ctl_s4.valid || res_ready;
	assign en_s3 = !ctl_s3.valid || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !ctl_s1.valid || en_s2;

	assign pix_ready    = en_s1;
	assign ctl_in.valid = pix_valid;
	assign ctl_in.dir   = direction_q;

	// stage 2 valid, mirrored here for the enable chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= ctl_s1.valid;
		end
	end

	rycc_operand #(.FRAC_BITS(FRAC_BITS)) u_operand (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en_s1),
		.ctl_in      (ctl_in),
		.comp_first  (comp_first),
		.comp_second (comp_second),
		.comp_third  (comp_third),
		.ctl_s1      (ctl_s1),
		.x_s1        (x_s1)
	);

	rycc_matmul #(.FRAC_BITS(FRAC_BITS)) u_matmul (
		.clk    (clk),
		.arst_n (arst_n),
		.en_s2  (en_s2),
		.en_s3  (en_s3),
		.ctl_s1 (ctl_s1),
		.x_s1   (x_s1),
		.ctl_s3 (ctl_s3),
		.acc_s3 (acc_s3)
	);

	rycc_round #(.FRAC_BITS(FRAC_BITS)) u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en_s4),
		.ctl_s3 (ctl_s3),
		.acc_s3 (acc_s3),
		.ctl_s4 (ctl_s4),
		.res_s4 (res_s4)
	);

	assign res_valid  = ctl_s4.valid;
	assign res_first  = res_s4[0];
	assign res_second = res_s4[1];
	assign res_third  = res_s4[2];

	// an empty output stage never blocks the input
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input stalled with empty output stage");

	// a ready receiver always lets a new request in
	a_ready_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> pix_ready)
		else $error("input stalled while receiver is ready");

	// a stalled result is not dropped
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("stalled result lost");

endmodule
`default_nettype wire
